[rtl/sha1bsh_pkg.sv]
// shared types, constants and round functions of the sha-1 byte stream hasher
package sha1bsh_pkg;

   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned CHAIN_WORDS = 5;
   localparam logic [6:0]  ROUND_ACC   = 7'd80;
   localparam logic [2:0]  LAST_INDEX  = 3'd4;
   localparam logic [7:0]  PAD_BYTE    = 8'h80;
   localparam logic [63:0] BYTE_BITS   = 64'd8;

   localparam logic [31:0] IV_0 = 32'h67452301;
   localparam logic [31:0] IV_1 = 32'hEFCDAB89;
   localparam logic [31:0] IV_2 = 32'h98BADCFE;
   localparam logic [31:0] IV_3 = 32'h10325476;
   localparam logic [31:0] IV_4 = 32'hC3D2E1F0;

   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef struct packed {
      logic       load_byte;
      logic       start;
      logic       round_en;
      logic       accum;
      logic [6:0] round;
      logic       pad;
      logic       zero;
      logic       put_len;
      logic       finish;
      logic [2:0] out_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic pos_last;
      logic pos_high;
   } dp_status_type;

   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      priority if (r < 7'd20) begin
         k = K_0;
      end else if (r < 7'd40) begin
         k = K_1;
      end else if (r < 7'd60) begin
         k = K_2;
      end else begin
         k = K_3;
      end
      return k;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      priority if (r < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (r < 7'd40) begin
         f = b ^ c ^ d;
      end else if (r < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

[rtl/sha1bsh_dp.sv]
// datapath: block buffer, message schedule, round logic, chaining value and bit count
module sha1bsh_dp
   import sha1bsh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  logic [7:0]    data_byte,
   output dp_status_type status,
   output logic [31:0]   digest_word
);

   logic [31:0] block_ff [BLOCK_WORDS];
   logic [31:0] block_in [BLOCK_WORDS];
   logic [31:0] win_ff   [BLOCK_WORDS];
   logic [31:0] win_in   [BLOCK_WORDS];
   logic [31:0] wv_ff    [CHAIN_WORDS];
   logic [31:0] wv_in    [CHAIN_WORDS];
   logic [31:0] chain_ff [CHAIN_WORDS];
   logic [31:0] chain_in [CHAIN_WORDS];
   logic [5:0]  pos_ff;
   logic [5:0]  pos_in;
   logic [63:0] count_ff;
   logic [63:0] count_in;

   logic [31:0] temp;
   logic [31:0] sched_next;
   logic [31:0] sched_mix;

   assign status.pos_last = (pos_ff == 6'd63);
   assign status.pos_high = (pos_ff >= 6'd56);

   // byte loading, padding, block clearing and length words
   always_comb begin
      block_in = block_ff;
      for (int j = 0; j < 16; j++) begin
         for (int b = 0; b < 4; b++) begin
            if (cmd.load_byte && (6'(4 * j + b) == pos_ff)) begin
               block_in[j][31 - 8 * b -: 8] = data_byte;
            end
            if (cmd.pad) begin
               if (6'(4 * j + b) == pos_ff) begin
                  block_in[j][31 - 8 * b -: 8] = PAD_BYTE;
               end else if (6'(4 * j + b) > pos_ff) begin
                  block_in[j][31 - 8 * b -: 8] = 8'h00;
               end
            end
            if (cmd.zero) begin
               block_in[j][31 - 8 * b -: 8] = 8'h00;
            end
         end
      end
      if (cmd.put_len) begin
         block_in[14] = count_ff[63:32];
         block_in[15] = count_ff[31:0];
      end
   end

   // window holds w[r] .. w[r+15] at round r
   assign sched_mix  = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
   assign sched_next = {sched_mix[30:0], sched_mix[31]};

   assign temp = {wv_ff[0][26:0], wv_ff[0][31:27]}
               + round_f(cmd.round, wv_ff[1], wv_ff[2], wv_ff[3])
               + wv_ff[4] + round_k(cmd.round) + win_ff[0];

   always_comb begin
      win_in   = win_ff;
      wv_in    = wv_ff;
      chain_in = chain_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      if (cmd.start) begin
         win_in = block_in;
         wv_in  = chain_ff;
      end else if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = sched_next;
         wv_in[0] = temp;
         wv_in[1] = wv_ff[0];
         wv_in[2] = {wv_ff[1][1:0], wv_ff[1][31:2]};
         wv_in[3] = wv_ff[2];
         wv_in[4] = wv_ff[3];
      end
      if (cmd.accum) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + wv_ff[i];
         end
      end
      if (cmd.load_byte) begin
         pos_in   = pos_ff + 6'd1;
         count_in = count_ff + BYTE_BITS;
      end
      if (cmd.finish) begin
         chain_in[0] = IV_0;
         chain_in[1] = IV_1;
         chain_in[2] = IV_2;
         chain_in[3] = IV_3;
         chain_in[4] = IV_4;
         pos_in      = 6'd0;
         count_in    = 64'd0;
      end
   end

   always_comb begin
      unique case (cmd.out_idx)
         3'd0:    digest_word = chain_ff[0];
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         3'd4:    digest_word = chain_ff[4];
         default: digest_word = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      win_ff   <= win_in;
      wv_ff    <= wv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff[0] <= IV_0;
         chain_ff[1] <= IV_1;
         chain_ff[2] <= IV_2;
         chain_ff[3] <= IV_3;
         chain_ff[4] <= IV_4;
         pos_ff      <= 6'd0;
         count_ff    <= 64'd0;
      end else begin
         chain_ff <= chain_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/sha1bsh_ctrl.sv]
// controller: item flow, finalization sequence, round counter and digest output
module sha1bsh_ctrl
   import sha1bsh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          byte_valid,
   input  logic          message_end,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [2:0]    word_index,
   output logic          last_word,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_LOAD  = 7'b0000001,
      ST_PAD   = 7'b0000010,
      ST_COMP1 = 7'b0000100,
      ST_CLR   = 7'b0001000,
      ST_COMP2 = 7'b0010000,
      ST_WAIT  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic        busy_ff, busy_in;
   logic [6:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        req_acc;

   // a byte that completes a block needs the round engine free
   assign req_stall  = (state_ff != ST_LOAD) || (busy_ff && status.pos_last);
   assign req_acc    = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == ST_OUT);
   assign word_index = idx_ff;
   assign last_word  = (idx_ff == LAST_INDEX);

   always_comb begin
      cmd          = '0;
      cmd.round    = round_ff;
      cmd.round_en = busy_ff && (round_ff != ROUND_ACC);
      cmd.accum    = busy_ff && (round_ff == ROUND_ACC);
      cmd.out_idx  = idx_ff;
      state_in     = state_ff;
      idx_in       = idx_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               cmd.load_byte = byte_valid;
               cmd.start     = byte_valid && status.pos_last;
               if (message_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.pad     = 1'b1;
            cmd.put_len = !status.pos_high;
            state_in    = ST_COMP1;
         end
         ST_COMP1: begin
            if (!busy_ff) begin
               cmd.start = 1'b1;
               state_in  = status.pos_high ? ST_CLR : ST_WAIT;
            end
         end
         ST_CLR: begin
            cmd.zero    = 1'b1;
            cmd.put_len = 1'b1;
            state_in    = ST_COMP2;
         end
         ST_COMP2: begin
            if (!busy_ff) begin
               cmd.start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!busy_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (idx_ff == LAST_INDEX) begin
                  cmd.finish = 1'b1;
                  idx_in     = 3'd0;
                  state_in   = ST_LOAD;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // round counter: 80 rounds, then a fold into the chaining value
   always_comb begin
      busy_in  = busy_ff;
      round_in = round_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         round_in = 7'd0;
      end else if (busy_ff) begin
         if (round_ff == ROUND_ACC) begin
            busy_in = 1'b0;
         end else begin
            round_in = round_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         busy_ff  <= 1'b0;
         round_ff <= 7'd0;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
      end
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("compression started while rounds still running");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (round_ff <= ROUND_ACC))
      else $error("round counter past fold cycle");

   a_out_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy_ff)
      else $error("digest shown while compression busy");

   a_fold_ends: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (round_ff == ROUND_ACC) && !cmd.start) |=> !busy_ff)
      else $error("engine still busy after fold cycle");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> (idx_ff == 3'd0))
      else $error("digest word index moved outside output phase");

endmodule

[rtl/sha1_byte_stream_hasher.sv]
// top level of the sha-1 byte stream hasher
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_type: data_byte, byte_valid, message_end
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_type: digest_word, word_index, last_word
//
// one item per cycle while loading; each block runs on the round engine
// (80 rounds, then a fold), overlapped with loading; a block-completing byte waits for it.
// message end: the block is padded and compressed, with a second padding block when the length
// does not fit, after any earlier block's compression; five items, held while rsp_stall is high.
// synchronous reset loads the initial vector and clears byte position and bit count.
module sha1_byte_stream_hasher
   import sha1bsh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [31:0]   digest_word;
   logic [2:0]    word_index;
   logic          last_word;

   sha1bsh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .byte_valid  (req_data.byte_valid),
      .message_end (req_data.message_end),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .word_index  (word_index),
      .last_word   (last_word),
      .status      (status),
      .cmd         (cmd)
   );

   sha1bsh_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_data.data_byte),
      .status      (status),
      .digest_word (digest_word)
   );

   assign rsp_data.digest_word = digest_word;
   assign rsp_data.word_index  = word_index;
   assign rsp_data.last_word   = last_word;

endmodule

[tb/sha1_byte_stream_hasher_tb.sv]
// self-checking testbench of the sha-1 byte stream hasher with a digest scoreboard
`timescale 1ns / 100ps

module sha1_byte_stream_hasher_tb;
   import sha1bsh_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 200;

   // predicts the digest items of every message from the accepted items and checks them in order
   class sha1_digest_scoreboard;
      bit [31:0] chain[5];
      bit [31:0] blk[16];
      bit [5:0]  pos;
      bit [63:0] nbits;
      rsp_type   digest_q[$];
      int        errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         chain[0] = IV_0;
         chain[1] = IV_1;
         chain[2] = IV_2;
         chain[3] = IV_3;
         chain[4] = IV_4;
         foreach (blk[i]) blk[i] = '0;
         pos   = '0;
         nbits = '0;
      endfunction

      function bit [31:0] rotl(input bit [31:0] x, input int n);
         return (x << n) | (x >> (32 - n));
      endfunction

      function void put_byte(input bit [5:0] p, input bit [7:0] v);
         blk[p[5:2]][8 * (3 - p[1:0]) +: 8] = v;
      endfunction

      function void compress();
         bit [31:0] w[16];
         bit [31:0] a, b, c, d, e, f, k, t, x;
         w = blk;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int r = 0; r < 80; r++) begin
            if (r < 16) begin
               x = w[r];
            end else begin
               x = rotl(w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15], 1);
               w[r & 15] = x;
            end
            if (r < 20) begin
               f = (b & c) | (~b & d);
               k = K_0;
            end else if (r < 40) begin
               f = b ^ c ^ d;
               k = K_1;
            end else if (r < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = K_2;
            end else begin
               f = b ^ c ^ d;
               k = K_3;
            end
            t = rotl(a, 5) + f + e + k + x;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      function void note_item(input req_type it);
         rsp_type r;
         if (it.byte_valid) begin
            put_byte(pos, it.data_byte);
            nbits += 64'd8;
            pos = pos + 6'd1;
            if (pos == 6'd0) compress();
         end
         if (!it.message_end) return;
         put_byte(pos, 8'h80);
         for (int i = int'(pos) + 1; i < 64; i++) put_byte(6'(i), 8'h00);
         // length does not fit behind the pad byte, one more block
         if (pos >= 6'd56) begin
            compress();
            foreach (blk[i]) blk[i] = '0;
         end
         blk[14] = nbits[63:32];
         blk[15] = nbits[31:0];
         compress();
         for (int i = 0; i < 5; i++) begin
            r.digest_word = chain[i];
            r.word_index  = 3'(i);
            r.last_word   = (i == 4);
            digest_q.push_back(r);
         end
         restart();
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(input rsp_type got);
         rsp_type want;
         if (digest_q.size() == 0) begin
            report($sformatf("digest item %h with nothing expected", got));
            return;
         end
         want = digest_q.pop_front();
         if (got.digest_word !== want.digest_word)
            report($sformatf("digest_word %h, expected %h (index %0d)",
                             got.digest_word, want.digest_word, want.word_index));
         if (got.word_index !== want.word_index)
            report($sformatf("word_index %0d, expected %0d", got.word_index, want.word_index));
         if (got.last_word !== want.last_word)
            report($sformatf("last_word %b, expected %b (index %0d)",
                             got.last_word, want.last_word, want.word_index));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   sha1_digest_scoreboard sb;
   int items_sent;
   bit calm;
   bit hold_rsp;
   bit rx_quiet;
   int idle_cycles;

   sha1_byte_stream_hasher u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // accepted items on both channels, plus a watchdog on cycles without progress
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_valid && !req_stall) sb.note_item(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("sha1_byte_stream_hasher_tb: errors");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, quiet windows and one long hold-off
   initial begin
      int win;
      win = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!calm && !rx_quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
         win++;
         if (win % 64 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
      end
   end

   function automatic req_type make_item(input bit [7:0] data, input bit vld, input bit fin);
      req_type it;
      it.data_byte   = data;
      it.byte_valid  = vld;
      it.message_end = fin;
      return it;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic drive_item(input req_type it);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic idle_sender(input int n);
      req_valid <= 1'b0;
      req_data  <= make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      repeat (n) @(negedge clock);
   endtask

   task automatic before_item(input bit gappy);
      if (gappy && !calm && $urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 14));
      // stray item with no byte and no end, ignored by the block
      if ($urandom_range(0, 11) == 0) begin
         drive_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
         items_sent++;
      end
   endtask

   task automatic send_message(input int len, input bit end_on_byte, input bit gappy);
      for (int i = 0; i < len; i++) begin
         before_item(gappy);
         drive_item(make_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && i == len - 1));
         items_sent++;
      end
      if (!(end_on_byte && len > 0)) begin
         before_item(gappy);
         drive_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
         items_sent++;
      end
   endtask

   function automatic int pick_length();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel <= 5) return $urandom_range(0, 12);
      if (sel <= 7) return $urandom_range(52, 66);
      if (sel == 8) return $urandom_range(112, 130);
      return $urandom_range(0, 3);
   endfunction

   task automatic run_random(input int target);
      int len;
      while (items_sent < target) begin
         len = pick_length();
         if (len > target - items_sent) len = target - items_sent;
         send_message(len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_for_digests();
      req_valid <= 1'b0;
      while (sb.digest_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      sb         = new();
      items_sent = 0;
      calm       = 1'b0;
      hold_rsp   = 1'b0;
      rx_quiet   = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: ignored item, empty message, "abc" ended on its byte,
      // extreme bytes with a bare end, extreme byte carrying the end, ignored item, empty message
      drive_item(make_item(8'hFF, 1'b0, 1'b0));
      drive_item(make_item(8'h00, 1'b0, 1'b1));
      drive_item(make_item(8'h61, 1'b1, 1'b0));
      drive_item(make_item(8'h62, 1'b1, 1'b0));
      drive_item(make_item(8'h63, 1'b1, 1'b1));
      drive_item(make_item(8'h00, 1'b1, 1'b0));
      drive_item(make_item(8'hFF, 1'b1, 1'b0));
      drive_item(make_item(8'hA5, 1'b0, 1'b1));
      drive_item(make_item(8'hFF, 1'b1, 1'b1));
      drive_item(make_item(8'h00, 1'b0, 1'b0));
      drive_item(make_item(8'h5A, 1'b0, 1'b1));
      items_sent = 11;

      run_random(120);

      // receiver holds off while messages keep coming, then the sender waits it out
      hold_rsp = 1'b1;
      for (int i = 0; i < 3; i++) send_message($urandom_range(4, 20), 1'($urandom_range(0, 1)), 1'b0);
      wait_for_digests();

      run_random(300);
      calm = 1'b1;
      run_random(380);

      idle_sender(1);
      wait_for_digests();
      repeat (DRAIN_CYCLES) @(negedge clock);
      while (sb.digest_q.size() != 0) begin
         sb.report($sformatf("digest item index %0d never arrived", sb.digest_q[0].word_index));
         void'(sb.digest_q.pop_front());
      end
      if (sb.errors == 0) begin
         $display("sha1_byte_stream_hasher_tb: clean");
      end else begin
         $display("sha1_byte_stream_hasher_tb: errors");
      end
      $finish;
   end

endmodule
